/* rtl/core/ace_pkg.sv */
package ace_pkg;

  localparam int unsigned EntriesDef = 32;
  localparam int unsigned AddrW = 5;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_LEARN  = 3'd1;
  localparam logic [2:0] OP_RESOLV = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [3:0] K_MISS    = 4'd0;
  localparam logic [3:0] K_HIT     = 4'd1;
  localparam logic [3:0] K_SEND    = 4'd2;
  localparam logic [3:0] K_QUEUED  = 4'd3;
  localparam logic [3:0] K_FULL    = 4'd4;
  localparam logic [3:0] K_REQUEST = 4'd5;
  localparam logic [3:0] K_FLUSH   = 4'd6;
  localparam logic [3:0] K_EXPIRED = 4'd7;
  localparam logic [3:0] K_DONE    = 4'd8;
  localparam logic [3:0] K_EVICTED = 4'd9;

  localparam logic [2:0] REG_TICK    = 3'd0;
  localparam logic [2:0] REG_STABLE  = 3'd1;
  localparam logic [2:0] REG_PENDING = 3'd2;
  localparam logic [2:0] REG_RETRY   = 3'd3;
  localparam logic [2:0] REG_MAXWAIT = 3'd4;
  localparam logic [2:0] REG_LIP     = 3'd5;
  localparam logic [2:0] REG_MASK    = 3'd6;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [1:0]  iface;
  } in_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] ip_out;
    logic [47:0] mac_out;
    logic [1:0]  iface_out;
    logic [7:0]  waiting_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] tick_period;
    logic [15:0] stable_timeout;
    logic [15:0] pending_timeout;
    logic [7:0]  retry_limit;
    logic [7:0]  max_waiting;
    logic [31:0] local_ip;
    logic [31:0] subnet_mask;
  } cfg_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_BCAST,
    CMD_SCAN,
    CMD_FOUND,
    CMD_MISS,
    CMD_EVICT,
    CMD_ALLOC,
    CMD_TICK,
    CMD_CLEAR,
    CMD_DONE
  } cmd_e;

  typedef struct packed {
    logic [2:0] op;
    logic       bcast;
    logic       match;
    logic       idx_last;
    logic       full;
    logic       tick_end;
  } status_t;

endpackage

/* rtl/core/ace_cfg.sv */
module ace_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ace_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output ace_pkg::cfg_t             cfg_o
);
  import ace_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] rsel;

  assign rsel   = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period     <= 16'd1000;
      cfg_q.stable_timeout  <= 16'd20000;
      cfg_q.pending_timeout <= 16'd1000;
      cfg_q.retry_limit     <= 8'd5;
      cfg_q.max_waiting     <= 8'd100;
      cfg_q.local_ip        <= 32'h0000_0000;
      cfg_q.subnet_mask     <= 32'hFFFF_FF00;
    end else if (psel && penable && pwrite) begin
      unique case (rsel)
        REG_TICK:    cfg_q.tick_period     <= pwdata[15:0];
        REG_STABLE:  cfg_q.stable_timeout  <= pwdata[15:0];
        REG_PENDING: cfg_q.pending_timeout <= pwdata[15:0];
        REG_RETRY:   cfg_q.retry_limit     <= pwdata[7:0];
        REG_MAXWAIT: cfg_q.max_waiting     <= pwdata[7:0];
        REG_LIP:     cfg_q.local_ip        <= pwdata;
        REG_MASK:    cfg_q.subnet_mask     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rsel)
      REG_TICK:    prdata = {16'd0, cfg_q.tick_period};
      REG_STABLE:  prdata = {16'd0, cfg_q.stable_timeout};
      REG_PENDING: prdata = {16'd0, cfg_q.pending_timeout};
      REG_RETRY:   prdata = {24'd0, cfg_q.retry_limit};
      REG_MAXWAIT: prdata = {24'd0, cfg_q.max_waiting};
      REG_LIP:     prdata = cfg_q.local_ip;
      REG_MASK:    prdata = cfg_q.subnet_mask;
      default:     prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/ace_ctrl.sv */
module ace_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  ace_pkg::status_t status_i,
  output ace_pkg::cmd_e    cmd_o,
  output logic             busy_o
);
  import ace_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_SCAN, S_ALLOC, S_TICK, S_CLEAR, S_DONE
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o   = CMD_LATCH;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.op == OP_LOOKUP && status_i.bcast) begin
          cmd_o   = CMD_BCAST;
          state_d = S_IDLE;
        end else if (status_i.op == OP_LOOKUP || status_i.op == OP_LEARN ||
                     status_i.op == OP_RESOLV) begin
          state_d = S_SCAN;
        end else if (status_i.op == OP_TICK) begin
          state_d = S_TICK;
        end else if (status_i.op == OP_CLEAR) begin
          state_d = S_CLEAR;
        end else begin
          cmd_o   = CMD_DONE;
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (status_i.match) begin
          cmd_o   = CMD_FOUND;
          state_d = (status_i.op == OP_LEARN) ? S_DONE : S_IDLE;
        end else if (status_i.idx_last) begin
          if (status_i.op == OP_LOOKUP) begin
            cmd_o   = CMD_MISS;
            state_d = S_IDLE;
          end else begin
            cmd_o   = status_i.full ? CMD_EVICT : CMD_NONE;
            state_d = S_ALLOC;
          end
        end else begin
          cmd_o = CMD_SCAN;
        end
      end
      S_ALLOC: begin
        cmd_o   = CMD_ALLOC;
        state_d = S_IDLE;
      end
      S_TICK: begin
        if (status_i.tick_end) begin
          cmd_o   = CMD_DONE;
          state_d = S_IDLE;
        end else begin
          cmd_o = CMD_TICK;
        end
      end
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.idx_last) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o   = CMD_DONE;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

/* rtl/core/ace_dpath.sv */
module ace_dpath #(
  parameter int unsigned ENTRIES = ace_pkg::EntriesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ace_pkg::cmd_e     cmd_i,
  input  ace_pkg::in_t      item_i,
  input  ace_pkg::cfg_t     cfg_i,
  output ace_pkg::status_t  status_o,
  output logic              res_valid_o,
  output ace_pkg::res_t     res_o
);
  import ace_pkg::*;

  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic        waiting;
    logic [15:0] timer;
    logic [7:0]  retr;
    logic [7:0]  queued;
    logic [1:0]  ifc;
  } ent_t;

  ent_t             ent_q [ENTRIES];
  logic [RW-1:0]    rec_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [CW-1:0]    cnt_q, cnt_d, cnt_m1;
  logic [CW-1:0]    p_q, p_d;
  logic [RW-1:0]    idx_q, idx_d;
  in_t              key_q;
  logic             rv_q, rv_d;
  res_t             res_q, res_d;

  logic [RW-1:0] tslot, lslot, fslot, lru_r, unl_slot, unl_r, frt_r, wr_slot;
  logic          unl_en, frt_en, alc_en, wr_en, bcast;
  ent_t          cur, tcur, lcur, wr_ent;
  logic [31:0]   host;
  logic [7:0]    rt;

  assign cnt_m1 = cnt_q - CW'(1);
  assign lru_r  = cnt_m1[RW-1:0];
  assign cur    = ent_q[idx_q];
  assign tcur   = ent_q[tslot];
  assign lcur   = ent_q[lslot];
  assign unl_r  = rec_q[unl_slot];
  assign frt_r  = rec_q[idx_q];
  assign rt     = tcur.retr - 8'd1;
  assign host   = ~cfg_i.subnet_mask;
  assign bcast  = (key_q.ip_addr == 32'hFFFF_FFFF) ||
                  ((host != 32'd0) && ((key_q.ip_addr & host) == host) &&
                   ((key_q.ip_addr & cfg_i.subnet_mask) ==
                    (cfg_i.local_ip & cfg_i.subnet_mask)));

  always_comb begin
    tslot = '0;
    lslot = '0;
    fslot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && rec_q[i] == p_q[RW-1:0]) tslot = RW'(i);
      if (valid_q[i] && rec_q[i] == lru_r)       lslot = RW'(i);
      if (!valid_q[i])                           fslot = RW'(i);
    end
  end

  assign status_o.op       = key_q.op;
  assign status_o.bcast    = bcast;
  assign status_o.match    = valid_q[idx_q] && (cur.ip == key_q.ip_addr);
  assign status_o.idx_last = (idx_q == RW'(ENTRIES - 1));
  assign status_o.full     = (cnt_q == CW'(ENTRIES));
  assign status_o.tick_end = (p_q >= cnt_q);

  always_comb begin
    unl_en   = 1'b0;
    unl_slot = idx_q;
    frt_en   = 1'b0;
    alc_en   = 1'b0;
    wr_en    = 1'b0;
    wr_slot  = idx_q;
    wr_ent   = cur;
    idx_d    = idx_q;
    p_d      = p_q;
    rv_d     = 1'b0;
    res_d    = '0;
    unique case (cmd_i)
      CMD_NONE: ;
      CMD_LATCH: begin
        idx_d = '0;
        p_d   = '0;
      end
      CMD_BCAST: begin
        rv_d  = 1'b1;
        res_d = '{K_HIT, key_q.ip_addr, 48'hFFFF_FFFF_FFFF, key_q.iface, 8'd0, 1'b1};
      end
      CMD_SCAN: idx_d = idx_q + RW'(1);
      CMD_FOUND: begin
        rv_d = 1'b1;
        case (key_q.op)
          OP_LOOKUP: begin
            if (cur.waiting)
              res_d = '{K_MISS, key_q.ip_addr, 48'd0, key_q.iface, 8'd0, 1'b1};
            else
              res_d = '{K_HIT, key_q.ip_addr, cur.mac, cur.ifc, 8'd0, 1'b1};
          end
          OP_LEARN: begin
            frt_en         = 1'b1;
            wr_en          = 1'b1;
            wr_ent.mac     = key_q.mac_addr;
            wr_ent.ifc     = key_q.iface;
            wr_ent.waiting = 1'b0;
            wr_ent.timer   = cfg_i.stable_timeout;
            wr_ent.queued  = 8'd0;
            rv_d           = (cur.queued != 8'd0);
            res_d = '{K_FLUSH, key_q.ip_addr, key_q.mac_addr, key_q.iface, cur.queued,
                      1'b0};
          end
          default: begin
            if (!cur.waiting) begin
              res_d = '{K_SEND, key_q.ip_addr, cur.mac, cur.ifc, 8'd0, 1'b1};
            end else if (cur.queued < cfg_i.max_waiting) begin
              wr_en         = 1'b1;
              wr_ent.queued = cur.queued + 8'd1;
              res_d = '{K_QUEUED, key_q.ip_addr, 48'd0, cur.ifc, cur.queued + 8'd1,
                        1'b1};
            end else begin
              res_d = '{K_FULL, key_q.ip_addr, 48'd0, cur.ifc, cur.queued, 1'b1};
            end
          end
        endcase
      end
      CMD_MISS: begin
        rv_d  = 1'b1;
        res_d = '{K_MISS, key_q.ip_addr, 48'd0, key_q.iface, 8'd0, 1'b1};
      end
      CMD_EVICT: begin
        unl_en   = 1'b1;
        unl_slot = lslot;
        rv_d     = 1'b1;
        res_d    = '{K_EVICTED, lcur.ip, 48'd0, lcur.ifc, lcur.queued, 1'b0};
      end
      CMD_ALLOC: begin
        alc_en      = 1'b1;
        wr_en       = 1'b1;
        wr_slot     = fslot;
        wr_ent.ip   = key_q.ip_addr;
        wr_ent.ifc  = key_q.iface;
        wr_ent.retr = cfg_i.retry_limit;
        rv_d        = 1'b1;
        if (key_q.op == OP_LEARN) begin
          wr_ent.mac     = key_q.mac_addr;
          wr_ent.waiting = 1'b0;
          wr_ent.timer   = cfg_i.stable_timeout;
          wr_ent.queued  = 8'd0;
          res_d = '{K_DONE, 32'd0, 48'd0, 2'd0, 8'd0, 1'b1};
        end else begin
          wr_ent.mac     = 48'd0;
          wr_ent.waiting = 1'b1;
          wr_ent.timer   = cfg_i.pending_timeout;
          wr_ent.queued  = 8'd1;
          res_d = '{K_REQUEST, key_q.ip_addr, 48'd0, key_q.iface, 8'd0, 1'b1};
        end
      end
      CMD_TICK: begin
        wr_slot = tslot;
        wr_ent  = tcur;
        if (tcur.timer > cfg_i.tick_period) begin
          wr_en        = 1'b1;
          wr_ent.timer = tcur.timer - cfg_i.tick_period;
          p_d          = p_q + CW'(1);
        end else if (!tcur.waiting) begin
          wr_en          = 1'b1;
          wr_ent.waiting = 1'b1;
          wr_ent.timer   = cfg_i.pending_timeout;
          wr_ent.retr    = cfg_i.retry_limit;
          p_d            = p_q + CW'(1);
          rv_d           = 1'b1;
          res_d = '{K_REQUEST, tcur.ip, 48'd0, tcur.ifc, 8'd0, 1'b0};
        end else if (rt == 8'd0) begin
          unl_en   = 1'b1;
          unl_slot = tslot;
          rv_d     = 1'b1;
          res_d = '{K_EXPIRED, tcur.ip, 48'd0, tcur.ifc, tcur.queued, 1'b0};
        end else begin
          wr_en        = 1'b1;
          wr_ent.retr  = rt;
          wr_ent.timer = cfg_i.pending_timeout;
          p_d          = p_q + CW'(1);
          rv_d         = 1'b1;
          res_d = '{K_REQUEST, tcur.ip, 48'd0, tcur.ifc, 8'd0, 1'b0};
        end
      end
      CMD_CLEAR: begin
        unl_en = valid_q[idx_q] && (cur.ifc == key_q.iface);
        idx_d  = idx_q + RW'(1);
      end
      CMD_DONE: begin
        rv_d  = 1'b1;
        res_d = '{K_DONE, 32'd0, 48'd0, 2'd0, 8'd0, 1'b1};
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (alc_en) cnt_d = cnt_q + CW'(1);
    if (unl_en) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      idx_q   <= '0;
      p_q     <= '0;
    end else begin
      if (unl_en) valid_q[unl_slot] <= 1'b0;
      if (alc_en) valid_q[fslot]    <= 1'b1;
      cnt_q <= cnt_d;
      rv_q  <= rv_d;
      idx_q <= idx_d;
      p_q   <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i == CMD_LATCH) key_q <= item_i;
    if (wr_en) ent_q[wr_slot] <= wr_ent;
    for (int i = 0; i < ENTRIES; i++) begin
      if (unl_en) begin
        if (valid_q[i] && rec_q[i] > unl_r) rec_q[i] <= rec_q[i] - RW'(1);
      end else if (frt_en) begin
        if (RW'(i) == idx_q)                     rec_q[i] <= '0;
        else if (valid_q[i] && rec_q[i] < frt_r) rec_q[i] <= rec_q[i] + RW'(1);
      end else if (alc_en) begin
        if (RW'(i) == fslot)  rec_q[i] <= '0;
        else if (valid_q[i])  rec_q[i] <= rec_q[i] + RW'(1);
      end
    end
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/arp_cache_engine_core.sv */
// ARP cache engine, most-recent-first order with entry aging.
// Command channel: an item (op, ip_addr, mac_addr, iface) is taken when
// start is high and busy is low; busy stays high until the item's last
// result has been issued.
// Result channel: each result is shown for one cycle with res_valid_o;
// res_o.last marks the final beat of an item. The receiver cannot stall.
// Lookup, learn and resolve walk the table one entry per cycle from slot 0
// until the address is found or the last slot is reached; an eviction is
// issued at the last slot, before the allocation. Tick visits each valid
// entry in recency order. Clear walks every slot. Broadcast lookups and
// other op codes finish without a table walk.
// One item at a time; the next may be taken in the cycle of the last beat.
// Registers sit on an APB port, word addresses 0 to 6, to be written only
// while the engine is idle; the block does not enforce this. pready is tied
// high. Reset empties the table and loads the default register values.
module arp_cache_engine_core #(
  parameter int unsigned ENTRIES = ace_pkg::EntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  ace_pkg::in_t              item_i,
  output logic                      res_valid_o,
  output ace_pkg::res_t             res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ace_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ace_pkg::*;

  cfg_t    cfg;
  status_t status;
  cmd_e    cmd;

  ace_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ace_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  ace_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_i       (cfg),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("last beat issued while engine still busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final beat issued while engine idle");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule

/* tb/sv/arp_cache_engine_core_checker.sv */
`timescale 1ns / 1ps

module arp_cache_engine_core_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  ace_pkg::in_t              item_i,
  input  logic                      res_valid_o,
  input  ace_pkg::res_t             res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [ace_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output int                        err_count,
  output int                        pending,
  output int                        beats_seen
);
  import ace_pkg::*;

  localparam int N = EntriesDef;

  cfg_t        cfg;
  logic        e_valid   [N];
  logic [31:0] e_ip      [N];
  logic [47:0] e_mac     [N];
  logic        e_waiting [N];
  int unsigned e_timer   [N];
  logic [7:0]  e_retries [N];
  logic [7:0]  e_queued  [N];
  logic [1:0]  e_iface   [N];
  int          e_rec     [N];

  res_t due_results[$];
  res_t step_results[$];

  function automatic void put(logic [3:0] kind, logic [31:0] ip, logic [47:0] mac,
                              logic [1:0] ifc, logic [7:0] cnt);
    res_t r;
    r.kind = kind;
    r.ip_out = ip;
    r.mac_out = mac;
    r.iface_out = ifc;
    r.waiting_count = cnt;
    r.last = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic int find_ip(logic [31:0] ip);
    for (int i = 0; i < N; i++) begin
      if (e_valid[i] && e_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    int r;
    r = e_rec[s];
    e_valid[s] = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (e_valid[i] && e_rec[i] > r) e_rec[i]--;
    end
  endfunction

  function automatic void move_front(int s);
    int r;
    r = e_rec[s];
    for (int i = 0; i < N; i++) begin
      if (i != s && e_valid[i] && e_rec[i] < r) e_rec[i]++;
    end
    e_rec[s] = 0;
  endfunction

  function automatic int take_slot();
    int cnt;
    int v;
    int s;
    cnt = 0;
    v = -1;
    s = 0;
    for (int i = 0; i < N; i++) cnt += e_valid[i];
    if (cnt >= N) begin
      for (int i = 0; i < N; i++) begin
        if (e_valid[i] && (v < 0 || e_rec[i] > e_rec[v])) v = i;
      end
      put(K_EVICTED, e_ip[v], '0, e_iface[v], e_queued[v]);
      drop_slot(v);
    end
    for (int i = 0; i < N; i++) begin
      if (!e_valid[i]) begin
        s = i;
        break;
      end
    end
    for (int i = 0; i < N; i++) begin
      if (e_valid[i]) e_rec[i]++;
    end
    e_valid[s] = 1'b1;
    e_rec[s] = 0;
    e_retries[s] = cfg.retry_limit;
    e_queued[s] = '0;
    e_waiting[s] = 1'b0;
    e_mac[s] = '0;
    return s;
  endfunction

  function automatic logic is_bcast(logic [31:0] ip);
    logic [31:0] host;
    host = ~cfg.subnet_mask;
    if (ip == 32'hFFFF_FFFF) return 1'b1;
    return host != 0 && (ip & host) == host &&
           (ip & cfg.subnet_mask) == (cfg.local_ip & cfg.subnet_mask);
  endfunction

  function automatic void age_all();
    int order[$];
    int s;
    for (int r = 0; r < N; r++) begin
      for (int i = 0; i < N; i++) begin
        if (e_valid[i] && e_rec[i] == r) begin
          order.insert(order.size(), i);
          break;
        end
      end
    end
    foreach (order[k]) begin
      s = order[k];
      if (e_timer[s] > cfg.tick_period) begin
        e_timer[s] -= cfg.tick_period;
      end else if (!e_waiting[s]) begin
        e_waiting[s] = 1'b1;
        e_timer[s] = cfg.pending_timeout;
        e_retries[s] = cfg.retry_limit;
        put(K_REQUEST, e_ip[s], '0, e_iface[s], '0);
      end else begin
        e_retries[s] = e_retries[s] - 8'd1;
        if (e_retries[s] == 0) begin
          put(K_EXPIRED, e_ip[s], '0, e_iface[s], e_queued[s]);
          drop_slot(s);
        end else begin
          e_timer[s] = cfg.pending_timeout;
          put(K_REQUEST, e_ip[s], '0, e_iface[s], '0);
        end
      end
    end
  endfunction

  function automatic void cache_step(in_t it);
    int s;
    step_results.delete();
    case (it.op)
      OP_LOOKUP: begin
        if (is_bcast(it.ip_addr)) begin
          put(K_HIT, it.ip_addr, '1, it.iface, '0);
        end else begin
          s = find_ip(it.ip_addr);
          if (s >= 0 && !e_waiting[s]) put(K_HIT, it.ip_addr, e_mac[s], e_iface[s], '0);
          else put(K_MISS, it.ip_addr, '0, it.iface, '0);
        end
      end
      OP_LEARN: begin
        s = find_ip(it.ip_addr);
        if (s < 0) begin
          s = take_slot();
          e_ip[s] = it.ip_addr;
        end else begin
          move_front(s);
          if (e_queued[s] != 0) put(K_FLUSH, it.ip_addr, it.mac_addr, it.iface, e_queued[s]);
          e_queued[s] = '0;
        end
        e_mac[s] = it.mac_addr;
        e_iface[s] = it.iface;
        e_waiting[s] = 1'b0;
        e_timer[s] = cfg.stable_timeout;
        put(K_DONE, '0, '0, '0, '0);
      end
      OP_RESOLV: begin
        s = find_ip(it.ip_addr);
        if (s >= 0) begin
          if (!e_waiting[s]) begin
            put(K_SEND, it.ip_addr, e_mac[s], e_iface[s], '0);
          end else if (e_queued[s] < cfg.max_waiting) begin
            e_queued[s]++;
            put(K_QUEUED, it.ip_addr, '0, e_iface[s], e_queued[s]);
          end else begin
            put(K_FULL, it.ip_addr, '0, e_iface[s], e_queued[s]);
          end
        end else begin
          s = take_slot();
          e_ip[s] = it.ip_addr;
          e_iface[s] = it.iface;
          e_waiting[s] = 1'b1;
          e_timer[s] = cfg.pending_timeout;
          e_queued[s] = 8'd1;
          put(K_REQUEST, it.ip_addr, '0, it.iface, '0);
        end
      end
      OP_TICK: begin
        age_all();
        put(K_DONE, '0, '0, '0, '0);
      end
      OP_CLEAR: begin
        for (int i = 0; i < N; i++) begin
          if (e_valid[i] && e_iface[i] == it.iface) drop_slot(i);
        end
        put(K_DONE, '0, '0, '0, '0);
      end
      default: put(K_DONE, '0, '0, '0, '0);
    endcase
    step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[k]) due_results.insert(due_results.size(), step_results[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      cfg = '{tick_period: 16'd1000, stable_timeout: 16'd20000, pending_timeout: 16'd1000,
              retry_limit: 8'd5, max_waiting: 8'd100, local_ip: '0,
              subnet_mask: 32'hFFFF_FF00};
      for (int i = 0; i < N; i++) e_valid[i] = 1'b0;
      due_results.delete();
      err_count <= 0;
      beats_seen <= 0;
      pending <= 0;
    end else begin
      if (res_valid_o) begin
        beats_seen <= beats_seen + 1;
        if (due_results.size() == 0) begin
          if (err_count < 10) $display("unexpected result beat %p", res_o);
          err_count <= err_count + 1;
        end else begin
          want = due_results.pop_front();
          if (res_o.kind !== want.kind || res_o.ip_out !== want.ip_out ||
              res_o.mac_out !== want.mac_out || res_o.iface_out !== want.iface_out ||
              res_o.waiting_count !== want.waiting_count || res_o.last !== want.last) begin
            if (err_count < 10) $display("mismatch: exp %p got %p", want, res_o);
            err_count <= err_count + 1;
          end
        end
      end
      if (start && !busy) cache_step(item_i);
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TICK:    cfg.tick_period = pwdata[15:0];
          REG_STABLE:  cfg.stable_timeout = pwdata[15:0];
          REG_PENDING: cfg.pending_timeout = pwdata[15:0];
          REG_RETRY:   cfg.retry_limit = pwdata[7:0];
          REG_MAXWAIT: cfg.max_waiting = pwdata[7:0];
          REG_LIP:     cfg.local_ip = pwdata;
          REG_MASK:    cfg.subnet_mask = pwdata;
          default: ;
        endcase
      end
      pending <= due_results.size();
    end
  end

endmodule

/* tb/sv/arp_cache_engine_core_test.sv */
`timescale 1ns / 1ps

module arp_cache_engine_core_test;
  import ace_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_t              item_i = '0;
  logic             res_valid_o;
  res_t             res_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  int               err_count;
  int               pending;
  int               beats_seen;
  int               cmds_sent = 0;
  logic [31:0]      ip_pool[40];

  always #6 clk_i = ~clk_i;

  arp_cache_engine_core u_dut (.*);

  arp_cache_engine_core_checker u_chk (.*);

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_all(logic [15:0] tp, logic [15:0] st, logic [15:0] pt, logic [7:0] rl,
                         logic [7:0] mw, logic [31:0] lip, logic [31:0] msk);
    drain();
    reg_write(REG_TICK, tp);
    reg_write(REG_STABLE, st);
    reg_write(REG_PENDING, pt);
    reg_write(REG_RETRY, rl);
    reg_write(REG_MAXWAIT, mw);
    reg_write(REG_LIP, lip);
    reg_write(REG_MASK, msk);
  endtask

  task automatic issue(logic [2:0] op, logic [31:0] ip, logic [47:0] mac, logic [1:0] ifc);
    int gap;
    int p;
    item_i <= '{op: op, ip_addr: ip, mac_addr: mac, iface: ifc};
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    cmds_sent++;
    p = $urandom_range(99);
    gap = (p < 60) ? 0 : (p < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_cmds(int count);
    int p;
    logic [2:0] op;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(99);
      op = (p < 25) ? OP_LEARN : (p < 55) ? OP_RESOLV : (p < 80) ? OP_LOOKUP :
           (p < 92) ? OP_TICK : (p < 95) ? OP_CLEAR : 3'($urandom_range(5, 7));
      issue(op, ($urandom_range(19) == 0) ? $urandom : ip_pool[$urandom_range(39)],
            {$urandom, $urandom}, 2'($urandom_range(3)));
      if (n == count / 2 && count > 100) begin
        start <= 1'b0;
        drain();
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    ip_pool[0] = 32'hFFFF_FFFF;
    ip_pool[1] = 32'h0000_0000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_write(REG_LIP, 32'h0A00_0005);

    issue(OP_LOOKUP, 32'hFFFF_FFFF, '0, 2'd3);
    issue(OP_LOOKUP, 32'h0A00_00FF, '0, 2'd1);
    issue(OP_LOOKUP, 32'h0A00_0005, '0, 2'd0);
    issue(OP_LEARN, 32'hC0A8_0001, '1, 2'd3);
    issue(OP_LOOKUP, 32'hC0A8_0001, '0, 2'd0);
    issue(OP_RESOLV, 32'hC0A8_0001, '0, 2'd0);
    issue(OP_RESOLV, 32'hC0A8_0002, '0, 2'd2);
    issue(OP_RESOLV, 32'hC0A8_0002, '0, 2'd2);
    issue(OP_LOOKUP, 32'hC0A8_0002, '0, 2'd2);
    issue(OP_LEARN, 32'hC0A8_0002, '0, 2'd1);
    issue(OP_LEARN, 32'h0000_0000, 48'h5555_AAAA_5555, 2'd0);
    issue(OP_TICK, '0, '0, 2'd0);
    issue(3'd5, '1, '1, 2'd3);
    issue(3'd6, '0, '0, 2'd0);
    issue(3'd7, '1, '1, 2'd3);
    issue(OP_CLEAR, '0, '0, 2'd3);
    issue(OP_CLEAR, '0, '0, 2'd0);
    start <= 1'b0;

    random_cmds(120);
    set_all(16'd1000, 16'd3000, 16'd1500, 8'd2, 8'd3, $urandom, 32'hFFFF_FF00);
    random_cmds(120);
    set_all(16'd65535, 16'd1, 16'd1, 8'd1, 8'd0, 32'h0, 32'hFFFF_FFFF);
    random_cmds(120);
    set_all(16'd1, 16'd65535, 16'd65535, 8'd255, 8'd255, $urandom, 32'h0);
    random_cmds(120);
    drain();

    $display("%0d commands over four register settings, %0d result beats checked",
             cmds_sent, beats_seen);
    $display("covered broadcast, hit/miss, queueing, flush, ageing, eviction and clear");
    if (err_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* arp_cache_engine_core.f */
rtl/core/ace_pkg.sv
rtl/core/ace_cfg.sv
rtl/core/ace_ctrl.sv
rtl/core/ace_dpath.sv
rtl/core/arp_cache_engine_core.sv
tb/sv/arp_cache_engine_core_checker.sv
tb/sv/arp_cache_engine_core_test.sv
